// ----- sv/ept_pkg.sv -----
// Package for the encoder position tracker: configuration types, reset values,
// register indexes and the controller command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ept_pkg;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic [1:0] RegPulsesPerRev = 2'd0;
  localparam logic [1:0] RegIndexDebounce = 2'd1;
  localparam logic [1:0] RegJumpLimit = 2'd2;
  localparam logic [1:0] RegSendPeriod = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [15:0] PulsesPerRevReset = 16'd5000;
  localparam logic [15:0] IndexDebounceReset = 16'd50;
  localparam logic [14:0] JumpLimitReset = 15'd2000;
  localparam logic [15:0] SendPeriodReset = 16'd10;

  // Number of remainder steps of the iterative divider.
  localparam int DivSteps = 32;

  typedef struct packed {
    logic [15:0] pulses_per_rev;
    logic [15:0] index_debounce_ms;
    logic [14:0] jump_limit;
    logic [15:0] send_period_ms;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic diff;
    logic index_stamp;
    logic div_start;
    logic clear_total;
    logic apply_rem;
    logic send;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_ok;
    logic mag_big;
    logic div_done;
    logic send_due;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/ept_divider.sv -----
// Iterative restoring divider that yields the remainder of a 32-bit magnitude
// by a 16-bit divisor, one quotient bit per cycle. Uses ept_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ept_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [15:0]      remainder
);
  import ept_pkg::*;

  localparam logic [4:0] LastStep = 5'(DivSteps - 1);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [16:0] trial;
  logic [16:0] trial_sub;
  logic        fits;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {remainder, dvd[31]};
    trial_sub = trial - {1'b0, divisor};
    fits = trial >= {1'b0, divisor};
  end

  // Control state of the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == LastStep);
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == LastStep) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Shift register of dividend bits and the partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      remainder <= '0;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      remainder <= fits ? trial_sub[15:0] : trial[15:0];
    end
  end

endmodule

`default_nettype wire

// ----- sv/ept_datapath.sv -----
// Datapath of the encoder position tracker: sample difference, position and
// delta accumulators, index realignment, send timing and the output register.
// Uses ept_pkg and ept_divider.
`timescale 1ns / 1ps
`default_nettype none

module ept_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ept_pkg::cfg_t    cfg,
  input  wire ept_pkg::cmd_t    cmd,
  output ept_pkg::status_t      status,
  input  wire logic [15:0]      raw_count,
  input  wire logic             index_edge,
  input  wire logic [31:0]      now_ms,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           delta_steps,
  output logic [31:0]           total_steps
);
  import ept_pkg::*;

  logic [15:0] in_sample;
  logic        in_edge;
  logic [31:0] in_now;

  logic [31:0] position_total;
  logic [31:0] delta_accum;
  logic [15:0] last_sample;
  logic [31:0] last_index_time;
  logic [31:0] last_send_time;

  logic [15:0] diff;
  logic [16:0] dmag;
  logic [31:0] dext;
  logic        take;
  logic        resync;
  logic        tot_neg;
  logic [31:0] tot_mag;
  logic [31:0] index_gap;
  logic [31:0] send_gap;
  logic [31:0] rem_ext;
  logic        div_done;
  logic [15:0] div_rem;

  // Wrapping sample difference, its exact magnitude and sign extension.
  always_comb begin
    diff = in_sample - last_sample;
    dmag = diff[15] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
    dext = {{16{diff[15]}}, diff};
    take = (dmag != 17'd0) && (dmag < {2'b00, cfg.jump_limit});
    resync = dmag >= {2'b00, cfg.jump_limit};
  end

  // Magnitude of the total, index debounce and send timing checks.
  always_comb begin
    tot_neg = position_total[31];
    tot_mag = tot_neg ? (32'd0 - position_total) : position_total;
    index_gap = in_now - last_index_time;
    send_gap = in_now - last_send_time;
    rem_ext = (cfg.pulses_per_rev == 16'd0) ? 32'd0 : {16'd0, div_rem};
    status.edge_ok = in_edge && (index_gap > {16'd0, cfg.index_debounce_ms});
    status.mag_big = tot_mag > {17'd0, cfg.pulses_per_rev[15:1]};
    status.div_done = div_done;
    status.send_due = send_gap >= {16'd0, cfg.send_period_ms};
    status.out_busy = out_valid && !out_ready;
  end

  ept_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (tot_mag),
    .divisor   (cfg.pulses_per_rev),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Input word holding register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_sample <= raw_count;
      in_edge <= index_edge;
      in_now <= now_ms;
    end
  end

  // Tracker state.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_total <= '0;
      delta_accum <= '0;
      last_sample <= '0;
      last_index_time <= '0;
      last_send_time <= '0;
    end else begin
      if (cmd.diff) begin
        if (take) begin
          position_total <= position_total + dext;
          delta_accum <= delta_accum + dext;
          last_sample <= in_sample;
        end else if (resync) begin
          last_sample <= in_sample;
        end
      end
      if (cmd.index_stamp) begin
        last_index_time <= in_now;
      end
      if (cmd.clear_total) begin
        position_total <= '0;
      end
      if (cmd.apply_rem) begin
        position_total <= tot_neg ? (position_total + rem_ext) : (position_total - rem_ext);
      end
      if (cmd.send) begin
        delta_accum <= '0;
        last_send_time <= in_now;
      end
    end
  end

  // Output register: holds the word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.send) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      delta_steps <= delta_accum;
      total_steps <= position_total;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ept_ctrl.sv -----
// Controller of the encoder position tracker: sequences one input word through
// difference, index realignment and send steps. Uses ept_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ept_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ept_pkg::status_t  status,
  output ept_pkg::cmd_t          cmd
);
  import ept_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIFF  = 6'b000010,
    ST_INDEX = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_APPLY = 6'b010000,
    ST_SEND  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff = 1'b1;
        state_next = ST_INDEX;
      end
      ST_INDEX: begin
        state_next = ST_SEND;
        if (status.edge_ok) begin
          cmd.index_stamp = 1'b1;
          if (status.mag_big) begin
            cmd.div_start = 1'b1;
            state_next = ST_DIV;
          end else begin
            cmd.clear_total = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply_rem = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (!status.send_due) begin
          state_next = ST_IDLE;
        end else if (!status.out_busy) begin
          cmd.send = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/encoder_position_tracker_core.sv -----
// Top level of the encoder position tracker: configuration registers and APB
// port, controller and datapath. Uses ept_pkg, ept_ctrl and ept_datapath.
//
// Usage:
//   The slave stream (s_*) takes one sample word: raw counter value and
//   millisecond time in s_tdata, the index edge flag in s_tuser. The master
//   stream (m_*) gives a delta/total word whenever the send period has run
//   out; other samples give no word.
//   A sample passes through the difference, index and send steps before the
//   next sample can be accepted. When an accepted index edge realigns a large
//   total, the 32-step remainder divider runs and an apply step follows it.
//   A result appears in the output register at the end of the sample's work.
//   If the receiver stalls, the word waits in the output register; the next
//   sample is accepted and worked on, and it waits only at its send step
//   while the earlier word is still not taken.
//   The APB port writes the four registers at byte addresses 0, 4, 8 and 12;
//   writes belong to idle periods. Synchronous reset loads the register
//   defaults, clears the position state and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module encoder_position_tracker_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Slave stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // [15:0] raw_count, [47:16] now_ms
  input  wire logic        s_tuser,  // [0] index_edge
  // Master stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,  // [31:0] delta_steps, [63:32] total_steps
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ept_pkg::*;

  cfg_t        cfg;
  cmd_t        cmd;
  status_t     status;
  logic        wr_en;
  logic [1:0]  reg_idx;
  logic [31:0] delta_steps;
  logic [31:0] total_steps;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulses_per_rev <= PulsesPerRevReset;
      cfg.index_debounce_ms <= IndexDebounceReset;
      cfg.jump_limit <= JumpLimitReset;
      cfg.send_period_ms <= SendPeriodReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegPulsesPerRev: cfg.pulses_per_rev <= pwdata[15:0];
        RegIndexDebounce: cfg.index_debounce_ms <= pwdata[15:0];
        RegJumpLimit: cfg.jump_limit <= pwdata[14:0];
        RegSendPeriod: cfg.send_period_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      RegPulsesPerRev: prdata = {16'd0, cfg.pulses_per_rev};
      RegIndexDebounce: prdata = {16'd0, cfg.index_debounce_ms};
      RegJumpLimit: prdata = {17'd0, cfg.jump_limit};
      RegSendPeriod: prdata = {16'd0, cfg.send_period_ms};
      default: prdata = 32'd0;
    endcase
  end

  ept_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ept_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .raw_count   (s_tdata[15:0]),
    .index_edge  (s_tuser),
    .now_ms      (s_tdata[47:16]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .delta_steps (delta_steps),
    .total_steps (total_steps)
  );

  assign m_tdata = {total_steps, delta_steps};

  // The divider finishes only while a sample is in work.
  a_div_done_busy: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> !s_tready)
    else $error("divider finished while the block was idle");

  // A result is never loaded over a word the receiver has not taken.
  a_send_free: assert property (@(posedge clk) disable iff (rst)
    cmd.send |-> !status.out_busy)
    else $error("result loaded over a pending output word");

  // The divider starts only for an accepted index edge on a large total.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (status.edge_ok && status.mag_big))
    else $error("divider started without a realignment");

  // An accepted sample takes the block out of idle in the next cycle.
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !s_tready)
    else $error("block stayed idle after accepting a sample");

endmodule

`default_nettype wire

// ----- verif/ept_telemetry_checker.sv -----
// Telemetry checker for the encoder position tracker: watches the sample, telemetry and
// configuration ports, predicts each telemetry word and compares it with the word sent.
// Depends on ept_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module ept_telemetry_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [47:0] s_tdata,  // [15:0] raw_count, [47:16] now_ms
  input  wire logic        s_tuser,  // [0] index_edge
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [63:0] m_tdata,  // [31:0] delta_steps, [63:32] total_steps
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               mismatches,
  output int               pending
);
  import ept_pkg::*;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] raw_count;
  } sample_t;

  typedef struct packed {
    logic [31:0] total_steps;
    logic [31:0] delta_steps;
  } telemetry_t;

  // Shadow copy of the configuration registers.
  logic [15:0] pulses_per_rev;
  logic [15:0] index_debounce_ms;
  logic [14:0] jump_limit;
  logic [15:0] send_period_ms;

  // Shadow copy of the tracking state.
  logic [31:0] position_total;
  logic [31:0] delta_accum;
  logic [15:0] last_sample;
  logic [31:0] last_index_time;
  logic [31:0] last_send_time;

  telemetry_t telemetry_due[$];
  int n_bad = 0;

  function automatic void restore_defaults();
    pulses_per_rev = PulsesPerRevReset;
    index_debounce_ms = IndexDebounceReset;
    jump_limit = JumpLimitReset;
    send_period_ms = SendPeriodReset;
    position_total = '0;
    delta_accum = '0;
    last_sample = '0;
    last_index_time = '0;
    last_send_time = '0;
  endfunction

  // Snap the total to a whole number of revolutions, truncating toward zero.
  // Small totals are cleared, and a zero revolution size leaves the total as it is.
  function automatic void realign_position();
    logic        neg;
    logic [31:0] mag;
    logic [31:0] rem;
    neg = position_total[31];
    mag = neg ? (32'd0 - position_total) : position_total;
    if (mag > {17'd0, pulses_per_rev[15:1]}) begin
      rem = (pulses_per_rev != 16'd0) ? (mag % {16'd0, pulses_per_rev}) : 32'd0;
      position_total = neg ? (position_total + rem) : (position_total - rem);
    end else begin
      position_total = '0;
    end
  endfunction

  // Apply one sample word: counter difference, then index edge, then send check.
  function automatic void track_sample(input sample_t smp, input logic idx_edge,
                                       output bit emit, output telemetry_t word);
    logic [15:0] diff;
    logic [16:0] dmag;
    logic [31:0] dext;
    logic [31:0] since_index;
    logic [31:0] since_send;
    diff = smp.raw_count - last_sample;
    dmag = diff[15] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
    dext = {{16{diff[15]}}, diff};
    if (dmag != 17'd0 && dmag < {2'd0, jump_limit}) begin
      position_total = position_total + dext;
      delta_accum = delta_accum + dext;
      last_sample = smp.raw_count;
    end else if (dmag >= {2'd0, jump_limit}) begin
      // Treated as counter noise: resync only.
      last_sample = smp.raw_count;
    end
    since_index = smp.now_ms - last_index_time;
    if (idx_edge && since_index > {16'd0, index_debounce_ms}) begin
      realign_position();
      last_index_time = smp.now_ms;
    end
    since_send = smp.now_ms - last_send_time;
    emit = (since_send >= {16'd0, send_period_ms});
    word.delta_steps = delta_accum;
    word.total_steps = position_total;
    if (emit) begin
      delta_accum = '0;
      last_send_time = smp.now_ms;
    end
  endfunction

  function automatic void report(input string what, input telemetry_t want,
                                 input telemetry_t got);
    n_bad++;
    if (n_bad <= 10) begin
      $display("%0t: telemetry word %s: want delta %0d total %0d, got delta %0d total %0d",
               $time, what, $signed(want.delta_steps), $signed(want.total_steps),
               $signed(got.delta_steps), $signed(got.total_steps));
    end
  endfunction

  initial restore_defaults();

  // Words leaving the block are checked before the sample of the same edge is
  // applied, since that sample cannot have produced a word yet.
  always @(posedge clk) begin
    telemetry_t got;
    telemetry_t want;
    bit         emit;
    if (rst) begin
      restore_defaults();
      telemetry_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = telemetry_t'(m_tdata);
        if (telemetry_due.size() == 0) begin
          report("with none due", '0, got);
        end else begin
          want = telemetry_due.pop_front();
          if (got.delta_steps !== want.delta_steps || got.total_steps !== want.total_steps) begin
            report("differs", want, got);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        track_sample(sample_t'(s_tdata), s_tuser, emit, want);
        if (emit) telemetry_due.push_back(want);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegPulsesPerRev: pulses_per_rev = pwdata[15:0];
          RegIndexDebounce: index_debounce_ms = pwdata[15:0];
          RegJumpLimit: jump_limit = pwdata[14:0];
          RegSendPeriod: send_period_ms = pwdata[15:0];
          default: ;
        endcase
      end
    end
    pending <= telemetry_due.size();
    mismatches <= n_bad;
  end

endmodule

// ----- verif/encoder_position_tracker_core_tb.sv -----
// Testbench top for encoder_position_tracker_core: clock, reset, sample stimulus,
// register writes, receiver stalls and the final verdict.
// Depends on ept_pkg, encoder_position_tracker_core and ept_telemetry_checker.
`timescale 1ns / 1ps

module encoder_position_tracker_core_tb;
  import ept_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 60;
  localparam int LongHold = 800;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // [15:0] raw_count, [47:16] now_ms
  logic        s_tuser = 1'b0;  // [0] index_edge
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;  // [31:0] delta_steps, [63:32] total_steps
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;

  encoder_position_tracker_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  ept_telemetry_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .mismatches(mismatches), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run time guard.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("encoder_position_tracker_core: mismatch");
      $finish;
    end
  end

  // Idle length: mostly none, often short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(12, 70);
  endfunction

  // Receiver: random stalls, calm stretches, and long hold-offs on request.
  int holds_asked = 0;
  int holds_done = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit rx_calm = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left = LongHold;
      end
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_calm) begin
        m_tready <= 1'b1;
      end else begin
        stall_left = pick_idle();
        if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Sender state, used only to shape the stimulus.
  logic [15:0] cur_raw = '0;
  logic [31:0] cur_now = '0;
  bit          tx_calm = 1'b0;
  int unsigned stim_jump = 2000;
  int unsigned stim_period = 10;

  // Offer one sample word and wait for it to be taken, then, unless calm, idle for a random gap.
  task automatic feed(input logic [15:0] raw, input logic idx_edge, input logic [31:0] now_t);
    int gap;
    s_tdata <= {now_t, raw};
    s_tuser <= idx_edge;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    cur_raw = raw;
    cur_now = now_t;
    gap = tx_calm ? 0 : pick_idle();
    if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and let every due telemetry word and pending sample finish.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // One random sample: mostly plausible counter motion, some noise jumps.
  task automatic random_sample(input bit drift_up);
    int          r;
    int          step;
    int          max_step;
    logic [15:0] raw;
    logic [31:0] now_t;
    logic        idx_edge;
    max_step = (stim_jump > 1) ? int'(stim_jump) - 1 : 1;
    r = $urandom_range(0, 99);
    raw = cur_raw;
    if (r < 70) begin
      step = $urandom_range(1, max_step);
      if (($urandom_range(0, 99) < 70) != drift_up) step = -step;
      raw = cur_raw + 16'(step);
    end else if (r < 78) begin
      // Right at or just under the noise threshold.
      step = ($urandom_range(0, 1) != 0) ? int'(stim_jump) : int'(stim_jump) - 1;
      if ($urandom_range(0, 1) != 0) step = -step;
      raw = cur_raw + 16'(step);
    end else if (r >= 88) begin
      raw = 16'($urandom);
    end
    idx_edge = ($urandom_range(0, 99) < 12);
    r = $urandom_range(0, 99);
    if (r < 85) now_t = cur_now + $urandom_range(0, stim_period / 2 + 2);
    else if (r < 97) now_t = cur_now + $urandom_range(0, 2 * stim_period + 2);
    else now_t = $urandom;
    feed(raw, idx_edge, now_t);
  endtask

  task automatic run_phase(input int unsigned ppr, input int unsigned debounce,
                           input int unsigned jump, input int unsigned period,
                           input int count, input bit drift_up, input bit hold);
    reg_write(RegPulsesPerRev, ppr);
    reg_write(RegIndexDebounce, debounce);
    reg_write(RegJumpLimit, jump);
    reg_write(RegSendPeriod, period);
    stim_jump = jump;
    stim_period = period;
    for (int i = 0; i < count; i++) begin
      if (hold && i == 40) holds_asked++;
      random_sample(drift_up);
    end
    drain();
  endtask

  initial begin
    logic [15:0] base;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (5) @(posedge clk);

    // Directed part with the reset settings: zero difference, the noise limit
    // and one under it, debounce at and past its limit, an index edge on a
    // small total, the most negative difference, realignment of positive and
    // negative totals, and time wrap.
    feed(16'd0, 1'b0, 32'd0);
    feed(16'd1999, 1'b0, 32'd5);
    feed(16'd3999, 1'b0, 32'd10);
    feed(16'd3998, 1'b0, 32'd19);
    feed(16'd3998, 1'b1, 32'd50);
    feed(16'd1999, 1'b1, 32'd51);
    feed(16'd1999, 1'b1, 32'd101);
    feed(16'd0, 1'b0, 32'd102);
    feed(16'h8000, 1'b0, 32'd103);
    feed(16'h7fff, 1'b0, 32'd104);
    for (int k = 1; k <= 5; k++) begin
      feed(16'h7fff + 16'(k * 1999), k == 5, (k == 5) ? 32'd200 : 32'(104 + k));
    end
    base = cur_raw;
    for (int k = 1; k <= 8; k++) begin
      feed(base - 16'(k * 1999), k == 8, (k == 8) ? 32'd300 : 32'(210 + k));
    end
    feed(cur_raw, 1'b0, 32'hffff_fff8);
    feed(cur_raw, 1'b0, 32'h0000_0002);
    drain();

    // Random part over several register settings, extremes included.
    run_phase(4096, 30, 20000, 8, 200, 1'b1, 1'b0);
    run_phase(1, 0, 32767, 0, 60, 1'b0, 1'b0);
    run_phase(65535, 65535, 1, 65535, 40, 1'b1, 1'b0);
    run_phase(0, 10, 15000, 2, 60, 1'b0, 1'b0);
    run_phase(7, 1, 0, 5, 40, 1'b1, 1'b0);
    run_phase(5000, 50, 2000, 10, 150, 1'b0, 1'b1);

    if (mismatches == 0) begin
      $display("encoder_position_tracker_core: match");
    end else begin
      $display("encoder_position_tracker_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/ept_pkg.sv
sv/ept_divider.sv
sv/ept_datapath.sv
sv/ept_ctrl.sv
sv/encoder_position_tracker_core.sv
verif/ept_telemetry_checker.sv
verif/encoder_position_tracker_core_tb.sv
